@@ design/dtc_pkg.sv @@
// Shared constants, codes and types for the distance-to-centroid scorer.
package dtc_pkg;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int VAL_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int SCORE_W    = 16;
  localparam int DIST_W     = 18;
  localparam int MAX_DIST_W = 16;
  localparam int DIMS_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int SUM_W     = 32;
  localparam int SQ_W      = 35;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int MUL_DIG_W = 4;
  localparam int FRAC_W    = 15;
  localparam int MM_W      = 2 * FRAC_W + 1;

  // Parameter defaults
  localparam int MAX_DIMS_DEF   = 16;
  localparam int MAX_POINTS_DEF = 65536;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINAL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_SCORE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_AVG    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_PTS = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 1'd1;

  // Constants
  localparam logic [VAL_W-1:0]      ONE_Q15      = 16'h8000;
  localparam logic [DIST_W-1:0]     DIST_MAX     = '1;
  localparam logic [SUM_W-1:0]      SUM_MAX      = '1;
  localparam logic [SQ_W-1:0]       SQ_MAX       = '1;
  localparam logic [MAX_DIST_W-1:0] MAX_DIST_RST = 16'd3277;
  localparam logic [DIMS_W-1:0]     DIMS_RST     = 5'd1;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_MUL,
    S_Q_SQRT,
    S_Q_DIV,
    S_THR_MUL,
    S_THR_SQRT,
    S_CEN_START,
    S_CEN_DIV,
    S_EMIT
  } state_e;

  // Handshake status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

@@ design/dtc_in_if.sv @@
// Input channel of the scorer: valid/ready with mode and value.
interface dtc_in_if;
  import dtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VAL_W-1:0]  value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

@@ design/dtc_out_if.sv @@
// Output channel of the scorer: valid/ready with status, score and distance.
interface dtc_out_if;
  import dtc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SCORE_W-1:0]  score;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, status, score, distance, input ready);
  modport sink   (input valid, status, score, distance, output ready);
endinterface

@@ design/distance_to_centroid_scorer.sv @@
// Distance-to-centroid scorer: per-dimension sample sums, a centroid average and
// a Euclidean distance with a linear decay score for each query point.
//
// Values are unsigned Q1.15. Items are taken one at a time. A clear or a sample
// element is taken without leaving the idle state. A query element runs the
// 4-digit serial multiplier that squares the difference to the centroid. The
// last element of a query point then runs the bit-serial square root (two
// radicand bits per cycle) and, when the distance is within a nonzero
// threshold, the bit-serial divide of the score, and then hands the result to
// the output register. A finalize item with points runs the threshold multiply
// and root, then one serial divide per dimension for the centroid. A result
// waiting in the output register does not hold off new items; only the cycle
// that would overwrite it waits. Configuration writes are registered and are
// taken at any time. The sample sums use one valid bit per dimension, so a
// clear takes effect at once with no sweep.
module distance_to_centroid_scorer #(
  parameter int MAX_DIMS   = dtc_pkg::MAX_DIMS_DEF,
  parameter int MAX_POINTS = dtc_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dtc_pkg::cfg_idx_t  cfg_idx_i,
  input  dtc_pkg::cfg_data_t cfg_data_i,
  dtc_in_if.sink             in_if,
  dtc_out_if.source          out_if
);
  import dtc_pkg::*;

  localparam int IDX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCNT_W    = $clog2(MAX_DIMS + 1);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int THR_RAD_W = MM_W + $clog2(MAX_DIMS);
  localparam int RAD_W     = (THR_RAD_W > SQ_W) ? THR_RAD_W : SQ_W;
  localparam int ROOT_W    = RAD_W / 2 + 1;
  localparam int THR_W     = THR_RAD_W / 2 + 1;
  localparam int DEN_W     = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int NUM_W     = (SUM_W + 1 > THR_W + FRAC_W + 1) ? SUM_W + 1 : THR_W + FRAC_W + 1;
  localparam int TRW       = MM_W + DCNT_W;

  // Configuration registers
  logic [MAX_DIST_W-1:0] max_dist_q;
  logic [DIMS_W-1:0]     dims_q;

  // Control state
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  d_q, d_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [THR_W-1:0]  thr_q, thr_d;
  logic              end_q, end_d;
  logic              out_valid_q, out_valid_d;

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SCORE_W-1:0]  res_score_q, res_score_d;
  logic [DIST_W-1:0]   res_dist_q, res_dist_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [SCORE_W-1:0]  out_score_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic                out_load;

  // Per-dimension stores
  logic [SUM_W-1:0]    sum_mem [MAX_DIMS];
  logic [MAX_DIMS-1:0] sum_vld_q;
  logic [VAL_W-1:0]    cen_mem [MAX_DIMS];
  logic                sum_we, sum_clr, cen_we;

  // Arithmetic units
  logic               mul_start, sqrt_start, div_start;
  logic [VAL_W-1:0]   mul_op;
  logic [PROD_W-1:0]  mul_prod;
  logic [RAD_W-1:0]   sqrt_rad;
  logic [ROOT_W-1:0]  sqrt_root;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [VAL_W-1:0]   div_quo;
  unit_st_t           mul_st, sqrt_st, div_st;

  // Datapath helpers
  logic                accept, in_rdy, out_free;
  logic [DCNT_W-1:0]   eff_dims;
  logic [IDX_W-1:0]    last_idx;
  logic                pt_end, cnt_full;
  logic [VAL_W-1:0]    m_eff, cen_rd, diff;
  logic [IDX_W-1:0]    rd_idx;
  logic [SUM_W-1:0]    sum_rd, sum_new;
  logic [SUM_W:0]      sum_add;
  logic [SQ_W:0]       sq_add;
  logic [SQ_W-1:0]     sq_sat;
  logic [TRW-1:0]      thr_rad;
  logic [DIST_W-1:0]   dist_c;

  // ---------------------------------------------------------------------------
  // Configuration: registered writes, no read-back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RST;
      dims_q     <= DIMS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_DIST: max_dist_q <= cfg_data_i[MAX_DIST_W-1:0];
        REG_DIMS:     dims_q     <= cfg_data_i[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dims into 1..MAX_DIMS and max_dist to one
  always_comb begin
    if (dims_q == '0) begin
      eff_dims = DCNT_W'(1);
    end else if (32'(dims_q) > 32'(MAX_DIMS)) begin
      eff_dims = DCNT_W'(MAX_DIMS);
    end else begin
      eff_dims = DCNT_W'(dims_q);
    end
  end

  assign last_idx = IDX_W'(eff_dims - DCNT_W'(1));
  assign pt_end   = (idx_q >= last_idx);
  assign cnt_full = (cnt_q == CNT_W'(MAX_POINTS));
  assign m_eff    = (max_dist_q > ONE_Q15) ? ONE_Q15 : max_dist_q;

  // ---------------------------------------------------------------------------
  // Shared datapath
  // ---------------------------------------------------------------------------
  assign in_rdy   = (state_q == S_IDLE);
  assign accept   = in_if.valid && in_rdy;
  assign out_free = !out_valid_q || out_if.ready;

  // Sample path reads the current element; finalize walks d_q
  assign rd_idx  = (state_q == S_IDLE) ? idx_q : d_q;
  assign sum_rd  = sum_vld_q[rd_idx] ? sum_mem[rd_idx] : '0;
  assign sum_add = {1'b0, sum_rd} + (SUM_W + 1)'(in_if.value);
  assign sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  // Query difference magnitude against the stored centroid
  assign cen_rd = cen_mem[idx_q];
  assign diff   = (in_if.value >= cen_rd) ? (in_if.value - cen_rd) : (cen_rd - in_if.value);

  // Saturating squared-distance accumulation
  assign sq_add = (SQ_W + 1)'(sq_q) + (SQ_W + 1)'(mul_prod);
  assign sq_sat = sq_add[SQ_W] ? SQ_MAX : sq_add[SQ_W-1:0];

  // Threshold radicand: max_dist^2 * dims
  assign thr_rad = TRW'(mul_prod[MM_W-1:0]) * TRW'(eff_dims);

  // Saturate the root to the distance field
  assign dist_c = (sqrt_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sqrt_root);

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_if.mode)
            MODE_QUERY: state_d = S_Q_MUL;
            MODE_FINAL: state_d = (cnt_q == '0) ? S_EMIT : S_THR_MUL;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_Q_MUL: begin
        if (mul_st.done) begin
          state_d = end_q ? S_Q_SQRT : S_IDLE;
        end
      end
      S_Q_SQRT: begin
        if (sqrt_st.done) begin
          if (thr_q != '0 && 32'(dist_c) <= 32'(thr_q)) begin
            state_d = S_Q_DIV;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_Q_DIV: begin
        if (div_st.done) begin
          state_d = S_EMIT;
        end
      end
      S_THR_MUL: begin
        if (mul_st.done) begin
          state_d = S_THR_SQRT;
        end
      end
      S_THR_SQRT: begin
        if (sqrt_st.done) begin
          state_d = S_CEN_START;
        end
      end
      S_CEN_START: begin
        state_d = S_CEN_DIV;
      end
      S_CEN_DIV: begin
        if (div_st.done) begin
          state_d = (d_q == last_idx) ? S_EMIT : S_CEN_START;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State outputs: unit starts, store writes and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    idx_d        = idx_q;
    d_d          = d_q;
    cnt_d        = cnt_q;
    sq_d         = sq_q;
    thr_d        = thr_q;
    end_d        = end_q;
    res_status_d = res_status_q;
    res_score_d  = res_score_q;
    res_dist_d   = res_dist_q;
    sum_we       = 1'b0;
    sum_clr      = 1'b0;
    cen_we       = 1'b0;
    mul_start    = 1'b0;
    mul_op       = m_eff;
    sqrt_start   = 1'b0;
    sqrt_rad     = RAD_W'(thr_rad);
    div_start    = 1'b0;
    div_num      = NUM_W'(sum_rd) + NUM_W'(cnt_q >> 1);
    div_den      = DEN_W'(cnt_q);
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_if.mode)
            MODE_CLEAR: begin
              // drop all sums and the point in progress
              sum_clr = 1'b1;
              cnt_d   = '0;
              idx_d   = '0;
              sq_d    = '0;
            end
            MODE_SAMPLE: begin
              sum_we = !cnt_full;
              idx_d  = pt_end ? '0 : idx_q + IDX_W'(1);
              if (pt_end && !cnt_full) begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            MODE_FINAL: begin
              idx_d = '0;
              sq_d  = '0;
              if (cnt_q == '0) begin
                res_status_d = STAT_NO_PTS;
                res_score_d  = '0;
                res_dist_d   = '0;
              end else begin
                mul_start = 1'b1;
              end
            end
            MODE_QUERY: begin
              // square the difference; note whether this element ends the point
              mul_start = 1'b1;
              mul_op    = diff;
              end_d     = pt_end;
              idx_d     = pt_end ? '0 : idx_q + IDX_W'(1);
            end
            default: ;
          endcase
        end
      end
      S_Q_MUL: begin
        if (mul_st.done) begin
          if (end_q) begin
            sqrt_start = 1'b1;
            sqrt_rad   = RAD_W'(sq_sat);
            sq_d       = '0;
          end else begin
            sq_d = sq_sat;
          end
        end
      end
      S_Q_SQRT: begin
        if (sqrt_st.done) begin
          res_status_d = STAT_SCORE;
          res_dist_d   = dist_c;
          res_score_d  = '0;
          if (thr_q == '0) begin
            // zero threshold scores one only on an exact hit
            res_score_d = (dist_c == '0) ? ONE_Q15 : '0;
          end else if (32'(dist_c) <= 32'(thr_q)) begin
            div_start = 1'b1;
            div_num   = (NUM_W'(dist_c) << FRAC_W) + NUM_W'(thr_q >> 1);
            div_den   = DEN_W'(thr_q);
          end
        end
      end
      S_Q_DIV: begin
        if (div_st.done) begin
          res_score_d = ONE_Q15 - div_quo;
        end
      end
      S_THR_MUL: begin
        if (mul_st.done) begin
          sqrt_start = 1'b1;
        end
      end
      S_THR_SQRT: begin
        if (sqrt_st.done) begin
          thr_d = THR_W'(sqrt_root);
          d_d   = '0;
        end
      end
      S_CEN_START: begin
        // rounded average: (sum + count/2) / count
        div_start = 1'b1;
      end
      S_CEN_DIV: begin
        if (div_st.done) begin
          cen_we = 1'b1;
          if (d_q == last_idx) begin
            res_status_d = STAT_AVG;
            res_score_d  = '0;
            res_dist_d   = DIST_W'(thr_q);
          end else begin
            d_d = d_q + IDX_W'(1);
          end
        end
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Output register: hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q && !out_if.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      sq_q        <= '0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      sq_q        <= sq_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q          <= d_d;
    end_q        <= end_d;
    res_status_q <= res_status_d;
    res_score_q  <= res_score_d;
    res_dist_q   <= res_dist_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_score_q  <= res_score_q;
      out_dist_q   <= res_dist_q;
    end
  end

  // Sum valid bits: clear empties every dimension at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= '0;
    end else if (sum_clr) begin
      sum_vld_q <= '0;
    end else if (sum_we) begin
      sum_vld_q[rd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[rd_idx] <= sum_new;
    end
    if (cen_we) begin
      cen_mem[d_q] <= div_quo;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic units
  // ---------------------------------------------------------------------------
  dtc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_op),
    .b_i     (mul_op),
    .prod_o  (mul_prod),
    .st_o    (mul_st)
  );

  dtc_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .root_o  (sqrt_root),
    .st_o    (sqrt_st)
  );

  dtc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (VAL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .st_o    (div_st)
  );

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_if.ready     = in_rdy;
  assign out_if.valid    = out_valid_q;
  assign out_if.status   = out_status_q;
  assign out_if.score    = out_score_q;
  assign out_if.distance = out_dist_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_unit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_st.busy, sqrt_st.busy, div_st.busy}))
    else $error("more than one arithmetic unit busy");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> !(mul_st.busy || sqrt_st.busy || div_st.busy))
    else $error("item accepted while an arithmetic unit is busy");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> (state_q == S_Q_MUL || state_q == S_THR_MUL))
    else $error("multiplier finished outside a multiply state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count above its limit");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_score_q <= ONE_Q15 &&
                     (out_status_q == STAT_SCORE || out_score_q == '0)))
    else $error("score out of range for its status");

endmodule

@@ design/dtc_mul.sv @@
// Digit-serial multiplier, one 4-bit digit of the multiplier per cycle.
module dtc_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dtc_pkg::VAL_W-1:0]   a_i,
  input  logic [dtc_pkg::VAL_W-1:0]   b_i,
  output logic [dtc_pkg::PROD_W-1:0]  prod_o,
  output dtc_pkg::unit_st_t           st_o
);
  import dtc_pkg::*;

  localparam int STEPS = VAL_W / MUL_DIG_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [VAL_W-1:0]           a_q, a_d, b_q, b_d;
  logic [PROD_W-1:0]          acc_q, acc_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [VAL_W+MUL_DIG_W-1:0] pp;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    pp     = a_q * b_q[VAL_W-1 -: MUL_DIG_W];
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = CNT_W'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one digit's partial product, most significant digit first
      acc_d = {acc_q[PROD_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}} + PROD_W'(pp);
      b_d   = b_q << MUL_DIG_W;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign prod_o    = acc_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

@@ design/dtc_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module dtc_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 18,
  parameter int Q_W   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [Q_W-1:0]    quo_o,
  output dtc_pkg::unit_st_t st_o
);
  import dtc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign quo_o     = num_q[Q_W-1:0];
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

@@ design/dtc_sqrt.sv @@
// Digit-serial square root, two radicand bits per cycle, rounded to nearest.
module dtc_sqrt #(
  parameter int RAD_W = 35
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAD_W-1:0]     rad_i,
  output logic [RAD_W/2:0]     root_o,
  output dtc_pkg::unit_st_t    st_o
);
  import dtc_pkg::*;

  localparam int STEPS  = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * STEPS;
  localparam int ROOT_W = RAD_W / 2 + 1;
  localparam int CNT_W  = $clog2(STEPS + 2);

  logic [PAD_W-1:0]  rad_q, rad_d;
  logic [STEPS:0]    rem_q, rem_d;
  logic [STEPS-1:0]  root_q, root_d;
  logic [ROOT_W-1:0] res_q, res_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [STEPS+2:0]  rem_sh, trial, rem_sub;
  logic              ge;

  always_comb begin
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    rem_sh  = {rem_q, rad_q[PAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    ge      = (rem_sh >= trial);
    if (start_i) begin
      rad_d  = PAD_W'(rad_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(STEPS + 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        // round up when the remainder exceeds the truncated root
        res_d  = ROOT_W'(root_q) + ROOT_W'(rem_q > {1'b0, root_q});
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = ge ? rem_sub[STEPS:0] : rem_sh[STEPS:0];
        root_d = {root_q[STEPS-2:0], ge};
        rad_d  = rad_q << 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

  assign root_o    = res_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule
